// ===== rtl/core/bps_pkg.sv =====
// Shared types and codes for the pairing sequencer.
`timescale 1ns / 1ps

package bps_pkg;

    localparam int unsigned OPCODE_W   = 4;
    localparam int unsigned CODE_W     = 2;
    localparam int unsigned HANDLE_W   = 12;
    localparam int unsigned PASSKEY_W  = 20;
    localparam int unsigned STATE_W    = 4;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned ADDR_W     = 3;

    // Event opcodes
    localparam logic [OPCODE_W-1:0] OP_START       = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_IOCAP_REQ   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_IOCAP_RESP  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_CONFIRM     = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_PASSKEY_REQ = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_PASSKEY_NTF = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_SSP_CPLT    = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_LINK_KEY    = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_AUTH_CPLT   = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_ENC_CHANGE  = 4'd9;

    // Status codes
    localparam logic [CODE_W-1:0] CODE_SUCCESS = 2'd0;
    localparam logic [CODE_W-1:0] CODE_FAILED  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_NOTSUPP = 2'd2;
    localparam logic [CODE_W-1:0] CODE_ENC_ERR = 2'd3;

    // Reported state numbers that the top level checks against
    localparam logic [STATE_W-1:0] STATE_INIT_START = 4'd1;
    localparam logic [STATE_W-1:0] STATE_FAILED     = 4'd9;

    // Register addresses
    localparam logic [ADDR_W-1:0] ADDR_LINK_HANDLE = 3'd0;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                start_encryption_ok;
        logic                encryption_status_ok;
        logic                encryption_enabled;
    } bps_event_t;

    typedef struct packed {
        logic                 send_auth_request;
        logic                 user_accept;
        logic                 passkey_valid;
        logic [PASSKEY_W-1:0] passkey_value;
        logic                 status_valid;
        logic [CODE_W-1:0]    status_kind;
        logic [HANDLE_W-1:0]  report_handle;
        logic [STATE_W-1:0]   current_state;
    } bps_result_t;

endpackage

// ===== rtl/core/bps_fsm.sv =====
// Pairing state register and the per-event transition and result logic.
`timescale 1ns / 1ps

module bps_fsm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  bps_pkg::bps_event_t          evt,
    input  logic [bps_pkg::HANDLE_W-1:0] link_handle,
    output bps_pkg::bps_result_t         result
);
    import bps_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        IDLE        = 4'd0,
        INIT_START  = 4'd1,
        INIT_WIOCAP = 4'd2,
        RESP_WIOREQ = 4'd3,
        WAIT_EVENT  = 4'd4,
        WAIT_CPLT   = 4'd5,
        WAIT_KEY    = 4'd6,
        INIT_WAUTH  = 4'd7,
        WAIT_ENC    = 4'd8,
        FAILED      = 4'd9
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic              initiator_reg;
    logic              initiator_next;
    logic              auth_req;
    logic              accept;
    logic              pk_valid;
    logic              st_valid;
    logic [CODE_W-1:0] st_code;

    always_comb
    begin
        phase_next     = phase_reg;
        initiator_next = initiator_reg;
        auth_req       = 1'b0;
        accept         = 1'b0;
        pk_valid       = 1'b0;
        st_valid       = 1'b0;
        st_code        = CODE_SUCCESS;
        case (evt.opcode)
            OP_START:
            begin
                if (phase_reg == IDLE)
                begin
                    initiator_next = 1'b1;
                    phase_next     = INIT_START;
                    auth_req       = 1'b1;
                end
            end
            OP_IOCAP_REQ:
            begin
                if (phase_reg == INIT_START)
                    phase_next = INIT_WIOCAP;
                else if (phase_reg == RESP_WIOREQ)
                    phase_next = WAIT_EVENT;
                else
                begin
                    phase_next = FAILED;
                    st_valid   = 1'b1;
                    st_code    = CODE_NOTSUPP;
                end
            end
            OP_IOCAP_RESP:
            begin
                if (phase_reg == IDLE)
                    phase_next = RESP_WIOREQ;
                else if (phase_reg == INIT_WIOCAP)
                    phase_next = WAIT_EVENT;
                else
                begin
                    phase_next = FAILED;
                    st_valid   = 1'b1;
                    st_code    = CODE_NOTSUPP;
                end
            end
            OP_CONFIRM, OP_PASSKEY_REQ, OP_PASSKEY_NTF:
            begin
                if (phase_reg == WAIT_EVENT)
                begin
                    phase_next = WAIT_CPLT;
                    accept     = (evt.opcode == OP_CONFIRM);
                    pk_valid   = (evt.opcode == OP_PASSKEY_REQ);
                end
                else
                begin
                    phase_next = FAILED;
                    st_valid   = 1'b1;
                    st_code    = CODE_NOTSUPP;
                end
            end
            OP_SSP_CPLT:
            begin
                if (phase_reg == WAIT_CPLT)
                    phase_next = WAIT_KEY;
                else
                begin
                    phase_next = FAILED;
                    st_valid   = 1'b1;
                    st_code    = CODE_NOTSUPP;
                end
            end
            OP_LINK_KEY, OP_AUTH_CPLT:
            begin
                if ((evt.opcode == OP_LINK_KEY && phase_reg == WAIT_KEY && initiator_reg))
                    phase_next = INIT_WAUTH;
                else if ((evt.opcode == OP_LINK_KEY && phase_reg == WAIT_KEY) ||
                         (evt.opcode == OP_AUTH_CPLT && phase_reg inside {INIT_START, INIT_WAUTH}))
                begin
                    // start encryption; a refused start ends pairing
                    if (evt.start_encryption_ok)
                        phase_next = WAIT_ENC;
                    else
                    begin
                        phase_next = FAILED;
                        st_valid   = 1'b1;
                        st_code    = CODE_FAILED;
                    end
                end
                else
                begin
                    phase_next = FAILED;
                    st_valid   = 1'b1;
                    st_code    = CODE_NOTSUPP;
                end
            end
            OP_ENC_CHANGE:
            begin
                // drop encryption changes that nobody waits for
                if (phase_reg == WAIT_ENC)
                begin
                    st_valid = 1'b1;
                    if (!evt.encryption_status_ok)
                        st_code = CODE_ENC_ERR;
                    else if (!evt.encryption_enabled)
                        st_code = CODE_FAILED;
                    else
                    begin
                        st_code        = CODE_SUCCESS;
                        phase_next     = IDLE;
                        initiator_next = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= IDLE;
            initiator_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            initiator_reg <= initiator_next;
        end
    end

    always_comb
    begin
        result.send_auth_request = auth_req;
        result.user_accept       = accept;
        result.passkey_valid     = pk_valid;
        result.passkey_value     = '0;
        result.status_valid      = st_valid;
        result.status_kind       = st_code;
        result.report_handle     = st_valid ? link_handle : '0;
        result.current_state     = phase_next;
    end

endmodule

// ===== rtl/core/bredr_pairing_sequencer_top.sv =====
// Top level of the pairing sequencer: stream ports, APB register, beat registers.
//
//  channel   | dir | handshake         | content
//  ----------+-----+-------------------+------------------------------------------
//  s_axis    | in  | s_tvalid/s_tready | one pairing event per beat
//  m_axis    | out | m_tvalid/m_tready | one result per event
//  apb       | in  | psel/penable      | link_handle at address 0
//
// An event is taken into the input register, resolved combinationally against the
// pairing state and written to the result register; while m_tready stays high, one
// event per cycle is sustained. The result register frees the input side, so a new
// event is taken while a finished result still waits. A stall on m_tready holds
// both registers once they are full. Reset returns to idle with no initiator.
`timescale 1ns / 1ps

module bredr_pairing_sequencer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // event
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] start_encryption_ok, [1] encryption_status_ok, [2] encryption_enabled
    input  logic [bps_pkg::IN_DATA_W-1:0]  s_tdata,
    // [3:0] opcode
    input  logic [bps_pkg::OPCODE_W-1:0]   s_tuser,
    // result
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] send_auth_request, [1] user_accept, [2] passkey_valid,
    // [22:3] passkey_value, [23] status_valid, [25:24] status_kind,
    // [37:26] report_handle, [41:38] current_state
    output logic [bps_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bps_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import bps_pkg::*;

    logic                  in_valid_reg;
    bps_event_t            in_data_reg;
    logic                  out_valid_reg;
    bps_result_t           out_data_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic                  advance;
    bps_result_t           result;
    bps_event_t            evt_in;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LINK_HANDLE) ? {{(32-HANDLE_W){1'b0}}, handle_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            handle_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_LINK_HANDLE)
            handle_reg <= pwdata[HANDLE_W-1:0];
    end

    assign evt_in.opcode               = s_tuser;
    assign evt_in.start_encryption_ok  = s_tdata[0];
    assign evt_in.encryption_status_ok = s_tdata[1];
    assign evt_in.encryption_enabled   = s_tdata[2];

    // move the held event on when the result slot is empty or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= evt_in;
    end

    bps_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .evt         (in_data_reg),
        .link_handle (handle_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_data_reg.current_state,
                       out_data_reg.report_handle,
                       out_data_reg.status_kind,
                       out_data_reg.status_valid,
                       out_data_reg.passkey_value,
                       out_data_reg.passkey_valid,
                       out_data_reg.user_accept,
                       out_data_reg.send_auth_request};

    // no code or handle without a status report
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_data_reg.status_valid) |->
            (out_data_reg.status_kind == CODE_SUCCESS && out_data_reg.report_handle == '0))
        else $error("status fields set without status_valid");

    // an accepted start always lands in the initiator start state, silently
    a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_data_reg.send_auth_request) |->
            (out_data_reg.current_state == STATE_INIT_START && !out_data_reg.status_valid))
        else $error("auth request with wrong state or status");

    // at most one kind of answer per result
    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({out_data_reg.send_auth_request, out_data_reg.user_accept,
                               out_data_reg.passkey_valid}))
        else $error("more than one answer in a result");

    // failed is left only by reset
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_data_reg.current_state == STATE_FAILED && out_valid_reg) |->
            (result.current_state == STATE_FAILED))
        else $error("left the failed state");

endmodule
